>>> hw/rtl/vsmr_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vsmr_pkg
// Shared types and constants for the voxel shape membership raster.
// ---------------------------------------------------------------------------
package vsmr_pkg;

   localparam int MAX_SHAPES_DEF = 128;
   localparam int COORD_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF  = 8;
   localparam int Z_BITS         = 9;
   localparam int COUNT_BITS     = 8;
   localparam int TRIG_BITS      = 16;
   localparam int CORDIC_STEPS   = 16;
   localparam logic signed [17:0] CORDIC_GAIN = 18'sd39797;
   localparam logic signed [15:0] TRIG_ONE    = 16'sd16384;

   localparam logic [1:0] KIND_BOX    = 2'd0;
   localparam logic [1:0] KIND_SPHERE = 2'd1;
   localparam logic [1:0] KIND_PRISM  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TRIG,
      ST_FETCH,
      ST_LOAD,
      ST_ROT,
      ST_TEST,
      ST_DONE
   } state_type;

   function automatic logic signed [17:0] atan_step(input logic [3:0] i);
      logic signed [17:0] v;
      unique case (i)
         4'd0:  v = 18'sd16384;
         4'd1:  v = 18'sd9672;
         4'd2:  v = 18'sd5110;
         4'd3:  v = 18'sd2594;
         4'd4:  v = 18'sd1302;
         4'd5:  v = 18'sd652;
         4'd6:  v = 18'sd326;
         4'd7:  v = 18'sd163;
         4'd8:  v = 18'sd81;
         4'd9:  v = 18'sd41;
         4'd10: v = 18'sd20;
         4'd11: v = 18'sd10;
         4'd12: v = 18'sd5;
         4'd13: v = 18'sd3;
         default: v = 18'sd1;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/vsmr_cordic.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vsmr_cordic
// Iterative sine and cosine, one cordic step per cycle, Q1.14 result.
// ---------------------------------------------------------------------------
module vsmr_cordic (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [15:0] angle,
   output logic             done,
   output logic [15:0]      sin_out,
   output logic [15:0]      cos_out
);

   logic signed [19:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic               flip_ff, flip_in;
   logic               busy_ff, busy_in;
   logic [3:0]         step_ff, step_in;
   logic               done_ff, done_in;
   logic signed [19:0] dx, dy, sr, cr;
   logic signed [15:0] sc, cc;

   always_comb begin
      dx = y_ff >>> step_ff;
      dy = x_ff >>> step_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      flip_in = flip_ff; busy_in = busy_ff; step_in = step_ff; done_in = 1'b0;
      if (start) begin
         flip_in = angle > 16'd32768;
         z_in = flip_in ? ($signed({4'd0, angle}) - 20'sd65536) : $signed({4'd0, angle});
         x_in = 20'(vsmr_pkg::CORDIC_GAIN);
         y_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[19]) begin
            x_in = x_ff - dx; y_in = y_ff + dy;
            z_in = z_ff - 20'(vsmr_pkg::atan_step(step_ff));
         end else begin
            x_in = x_ff + dx; y_in = y_ff - dy;
            z_in = z_ff + 20'(vsmr_pkg::atan_step(step_ff));
         end
         step_in = step_ff + 4'd1;
         if (step_ff == 4'(vsmr_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; flip_ff <= flip_in; step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_comb begin
      sr = (y_ff + 20'sd2) >>> 2;
      cr = (x_ff + 20'sd2) >>> 2;
      if (sr > 20'sd16384) sc = vsmr_pkg::TRIG_ONE;
      else if (sr < -20'sd16384) sc = -vsmr_pkg::TRIG_ONE;
      else sc = sr[15:0];
      if (cr > 20'sd16384) cc = vsmr_pkg::TRIG_ONE;
      else if (cr < -20'sd16384) cc = -vsmr_pkg::TRIG_ONE;
      else cc = cr[15:0];
      sin_out = flip_ff ? 16'(-sc) : sc;
      cos_out = flip_ff ? 16'(-cc) : cc;
   end

   assign done = done_ff;

endmodule
`default_nettype wire

>>> hw/rtl/voxel_shape_membership_raster.sv
`default_nettype none
// ---------------------------------------------------------------------------
// voxel_shape_membership_raster
// Stores rotated boxes, spheres and prisms in a table, tests a voxel against
// them and returns the color of the first shape that holds it.
// ---------------------------------------------------------------------------
//  channel | direction | ports
//  req     | in        | req_valid, req_ready, req_* fields
//  rsp     | out       | rsp_valid, rsp_ready, rsp_hit, rsp_color_*
//  csr     | in        | csr_write, csr_data (shape_count)
//
//  a write word runs its three angles through the shared cordic unit
//  a query runs each tested shape through the shared multiplier
//  one item at a time; req_ready is low while an item is at work or its
//  result waits in the output register
//  synchronous reset clears control state and shape_count; tables stay
// ---------------------------------------------------------------------------
module voxel_shape_membership_raster #(
   parameter int MAX_SHAPES = vsmr_pkg::MAX_SHAPES_DEF,
   parameter int COORD_BITS = vsmr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = vsmr_pkg::FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_type,
   input  wire logic [6:0]            req_shape_index,
   input  wire logic [1:0]            req_shape_kind,
   input  wire logic [COORD_BITS-1:0] req_coord_x,
   input  wire logic [COORD_BITS-1:0] req_coord_y,
   input  wire logic [8:0]            req_coord_z,
   input  wire logic [23:0]           req_shape_size,
   input  wire logic [15:0]           req_angle_x,
   input  wire logic [15:0]           req_angle_y,
   input  wire logic [15:0]           req_angle_z,
   input  wire logic [23:0]           req_shape_color,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_hit,
   output logic [7:0]                 rsp_color_r,
   output logic [7:0]                 rsp_color_g,
   output logic [7:0]                 rsp_color_b,
   input  wire logic                  csr_write,
   input  wire logic [7:0]            csr_data
);

   localparam int IDX_BITS = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
   localparam int CNT_BITS = $clog2(MAX_SHAPES + 1);
   localparam int P_BITS   = COORD_BITS + FRAC_BITS + 4;
   localparam int W_BITS   = 2 * P_BITS + 4;
   localparam int CEN_BITS = 2 * COORD_BITS + vsmr_pkg::Z_BITS;

   // tables
   logic [1:0]          kind_mem  [MAX_SHAPES];
   logic [CEN_BITS-1:0] cen_mem   [MAX_SHAPES];
   logic [23:0]         size_mem  [MAX_SHAPES];
   logic [95:0]         trig_mem  [MAX_SHAPES];
   logic [23:0]         color_mem [MAX_SHAPES];

   vsmr_pkg::state_type state_ff, state_in;
   logic [7:0]          count_ff;
   logic                wr_ff, wr_in;
   logic [6:0]          widx_ff, widx_in;
   logic [1:0]          wkind_ff, wkind_in;
   logic [CEN_BITS-1:0] wcen_ff, wcen_in;
   logic [23:0]         wsize_ff, wsize_in, wcolor_ff, wcolor_in;
   logic [15:0]         ang_ff [3];
   logic [15:0]         ang_in [3];
   logic [95:0]         trig_acc_ff, trig_acc_in;
   logic [1:0]          ang_sel_ff, ang_sel_in;
   logic                cstart;
   logic                cdone;
   logic [15:0]         csin, ccos;

   logic [IDX_BITS-1:0] ent_ff, ent_in;
   logic [CNT_BITS-1:0] lim_ff, lim_in;
   logic [3:0]          ph_ff, ph_in;

   // registered reads
   logic [1:0]          rkind_ff;
   logic [CEN_BITS-1:0] rcen_ff;
   logic [23:0]         rsize_ff, rcolor_ff;
   logic [95:0]         rtrig_ff;
   logic                rd_en;

   logic signed [P_BITS-1:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in, t_ff, t_in;
   logic signed [W_BITS-1:0] acc_ff, acc_in;
   logic signed [P_BITS-1:0] ma;
   logic signed [P_BITS-1:0] mb;
   logic signed [2*P_BITS-1:0] prod_raw;
   logic signed [W_BITS-1:0] prod;
   logic signed [P_BITS-1:0] rnd;
   logic signed [W_BITS-1:0] d_ff, d_in;
   logic signed [W_BITS-1:0] a_ff, a_in, b_ff, b_in;
   logic                     sph_ff, sph_in;

   logic                rv_ff, rv_in, rh_ff, rh_in;
   logic [23:0]         rc_ff, rc_in;

   vsmr_cordic u_cordic (
      .clock(clock), .reset(reset), .start(cstart),
      .angle(ang_ff[ang_sel_ff]), .done(cdone), .sin_out(csin), .cos_out(ccos)
   );

   function automatic logic signed [16:0] tf(input logic [95:0] w, input int slot);
      return 17'(signed'(w[slot*16 +: 16]));
   endfunction

   // table writes and reads
   always_ff @(posedge clock) begin
      if (state_ff == vsmr_pkg::ST_DONE && wr_ff && 32'(widx_ff) < MAX_SHAPES) begin
         kind_mem[widx_ff[IDX_BITS-1:0]]  <= wkind_ff;
         cen_mem[widx_ff[IDX_BITS-1:0]]   <= wcen_ff;
         size_mem[widx_ff[IDX_BITS-1:0]]  <= wsize_ff;
         color_mem[widx_ff[IDX_BITS-1:0]] <= wcolor_ff;
         trig_mem[widx_ff[IDX_BITS-1:0]]  <= trig_acc_ff;
      end
      if (rd_en) begin
         rkind_ff  <= kind_mem[ent_ff];
         rcen_ff   <= cen_mem[ent_ff];
         rsize_ff  <= size_mem[ent_ff];
         rcolor_ff <= color_mem[ent_ff];
         rtrig_ff  <= trig_mem[ent_ff];
      end
   end

   logic signed [P_BITS-1:0] hx, hy, hz, apx, apy, apz, pyh;
   logic                     in_box, in_prism, hit_now, neg_e, pos_e;
   logic signed [W_BITS-1:0] e1, e3;

   always_comb begin
      hx = P_BITS'(rsize_ff[7:0])   <<< (FRAC_BITS - 1);
      hy = P_BITS'(rsize_ff[15:8])  <<< (FRAC_BITS - 1);
      hz = P_BITS'(rsize_ff[23:16]) <<< (FRAC_BITS - 1);
      apx = px_ff[P_BITS-1] ? -px_ff : px_ff;
      apy = py_ff[P_BITS-1] ? -py_ff : py_ff;
      apz = pz_ff[P_BITS-1] ? -pz_ff : pz_ff;
      in_box = apx <= hx && apy <= hy && apz <= hz;
      // edge functions from 2*hy*px and hx*(hy-py); the base edge has the sign of py+hy
      e1 = a_ff + b_ff;
      e3 = b_ff - a_ff;
      pyh = py_ff + hy;
      neg_e = e1 < 0 || e3 < 0 || (hx != 0 && pyh < 0);
      pos_e = e1 > 0 || e3 > 0 || (hx != 0 && pyh > 0);
      in_prism = apz <= hz && !(neg_e && pos_e);
      unique case (rkind_ff)
         vsmr_pkg::KIND_BOX:    hit_now = in_box;
         vsmr_pkg::KIND_SPHERE: hit_now = sph_ff;
         vsmr_pkg::KIND_PRISM:  hit_now = in_prism;
         default:               hit_now = 1'b0;
      endcase
   end

   // shared multiplier
   assign prod_raw = ma * mb;
   assign prod = W_BITS'(prod_raw);
   assign rnd  = P_BITS'((acc_ff + prod + W_BITS'(8192)) >>> 14);

   always_comb begin
      state_in = state_ff;
      wr_in = wr_ff; widx_in = widx_ff; wkind_in = wkind_ff; wcen_in = wcen_ff;
      wsize_in = wsize_ff; wcolor_in = wcolor_ff;
      for (int i = 0; i < 3; i++) ang_in[i] = ang_ff[i];
      trig_acc_in = trig_acc_ff; ang_sel_in = ang_sel_ff;
      cstart = 1'b0; rd_en = 1'b0;
      ent_in = ent_ff; lim_in = lim_ff; ph_in = ph_ff;
      px_in = px_ff; py_in = py_ff; pz_in = pz_ff; t_in = t_ff;
      acc_in = acc_ff; d_in = d_ff; a_in = a_ff; b_in = b_ff; sph_in = sph_ff;
      rv_in = rv_ff; rh_in = rh_ff; rc_in = rc_ff;
      ma = '0; mb = '0;
      req_ready = 1'b0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         vsmr_pkg::ST_IDLE: begin
            req_ready = !rv_ff;
            if (req_valid && !rv_ff) begin
               wr_in = !req_type;
               widx_in = req_shape_index; wkind_in = req_shape_kind;
               wcen_in = {req_coord_z, req_coord_y, req_coord_x};
               wsize_in = req_shape_size; wcolor_in = req_shape_color;
               ang_in[0] = req_angle_x; ang_in[1] = req_angle_y; ang_in[2] = req_angle_z;
               ang_sel_in = '0; ent_in = '0;
               lim_in = (32'(count_ff) > MAX_SHAPES) ? CNT_BITS'(MAX_SHAPES)
                                                      : CNT_BITS'(count_ff);
               rh_in = 1'b0; rc_in = '0;
               state_in = req_type ? vsmr_pkg::ST_FETCH : vsmr_pkg::ST_TRIG;
               ph_in = '0;
            end
         end
         vsmr_pkg::ST_TRIG: begin
            if (ph_ff == 4'd0) begin
               cstart = 1'b1;
               ph_in = 4'd1;
            end else if (cdone) begin
               trig_acc_in[ang_sel_ff*32 +: 32] = {ccos, csin};
               ph_in = 4'd0;
               if (ang_sel_ff == 2'd2) state_in = vsmr_pkg::ST_DONE;
               ang_sel_in = ang_sel_ff + 2'd1;
            end
         end
         vsmr_pkg::ST_FETCH: begin
            if (32'(ent_ff) >= 32'(lim_ff)) state_in = vsmr_pkg::ST_DONE;
            else begin
               rd_en = 1'b1;
               state_in = vsmr_pkg::ST_LOAD;
            end
         end
         vsmr_pkg::ST_LOAD: begin
            px_in = P_BITS'($signed({1'b0, wcen_ff[COORD_BITS-1:0]})
                    - $signed({1'b0, rcen_ff[COORD_BITS-1:0]})) <<< FRAC_BITS;
            py_in = P_BITS'($signed({1'b0, wcen_ff[2*COORD_BITS-1:COORD_BITS]})
                    - $signed({1'b0, rcen_ff[2*COORD_BITS-1:COORD_BITS]})) <<< FRAC_BITS;
            pz_in = P_BITS'($signed({1'b0, wcen_ff[CEN_BITS-1:2*COORD_BITS]})
                    - $signed({1'b0, rcen_ff[CEN_BITS-1:2*COORD_BITS]})) <<< FRAC_BITS;
            ph_in = '0; acc_in = '0;
            state_in = vsmr_pkg::ST_ROT;
         end
         vsmr_pkg::ST_ROT: begin
            // twelve products, two per rotated component
            unique case (ph_ff)
               4'd0:  begin ma = py_ff; mb = P_BITS'(tf(rtrig_ff, 1)); acc_in = prod; end
               4'd1:  begin ma = pz_ff; mb = P_BITS'(tf(rtrig_ff, 0)); t_in = rnd;
                            acc_in = '0; end
               4'd2:  begin ma = py_ff; mb = P_BITS'(-tf(rtrig_ff, 0)); acc_in = prod; end
               4'd3:  begin ma = pz_ff; mb = P_BITS'(tf(rtrig_ff, 1)); pz_in = rnd;
                            py_in = t_ff; acc_in = '0; end
               4'd4:  begin ma = px_ff; mb = P_BITS'(tf(rtrig_ff, 3)); acc_in = prod; end
               4'd5:  begin ma = pz_ff; mb = P_BITS'(-tf(rtrig_ff, 2)); t_in = rnd;
                            acc_in = '0; end
               4'd6:  begin ma = px_ff; mb = P_BITS'(tf(rtrig_ff, 2)); acc_in = prod; end
               4'd7:  begin ma = pz_ff; mb = P_BITS'(tf(rtrig_ff, 3)); pz_in = rnd;
                            px_in = t_ff; acc_in = '0; end
               4'd8:  begin ma = px_ff; mb = P_BITS'(tf(rtrig_ff, 5)); acc_in = prod; end
               4'd9:  begin ma = py_ff; mb = P_BITS'(tf(rtrig_ff, 4)); t_in = rnd;
                            acc_in = '0; end
               4'd10: begin ma = px_ff; mb = P_BITS'(-tf(rtrig_ff, 4)); acc_in = prod; end
               default: begin ma = py_ff; mb = P_BITS'(tf(rtrig_ff, 5)); py_in = rnd;
                            px_in = t_ff; acc_in = '0; end
            endcase
            ph_in = ph_ff + 4'd1;
            if (ph_ff == 4'd11) begin
               state_in = vsmr_pkg::ST_TEST;
               ph_in = '0;
            end
         end
         vsmr_pkg::ST_TEST: begin
            // squares for the sphere, then the two prism edge products
            ph_in = ph_ff + 4'd1;
            unique case (ph_ff)
               4'd0: begin ma = px_ff; mb = px_ff; d_in = prod; end
               4'd1: begin ma = py_ff; mb = py_ff; d_in = d_ff + prod; end
               4'd2: begin ma = pz_ff; mb = pz_ff; d_in = d_ff + prod; end
               4'd3: begin ma = hx; mb = hx; sph_in = d_ff <= prod; end
               4'd4: begin ma = px_ff; mb = hy + hy; a_in = prod; end
               4'd5: begin ma = hx; mb = hy - py_ff; b_in = prod; end
               default: begin
                  if (hit_now) begin
                     rh_in = 1'b1; rc_in = rcolor_ff;
                     state_in = vsmr_pkg::ST_DONE;
                  end else begin
                     ent_in = ent_ff + IDX_BITS'(1);
                     if (32'(ent_ff) + 1 >= 32'(lim_ff)) state_in = vsmr_pkg::ST_DONE;
                     else state_in = vsmr_pkg::ST_FETCH;
                  end
               end
            endcase
         end
         vsmr_pkg::ST_DONE: begin
            if (!wr_ff) rv_in = 1'b1;
            state_in = vsmr_pkg::ST_IDLE;
         end
         default: state_in = vsmr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      wr_ff <= wr_in; widx_ff <= widx_in; wkind_ff <= wkind_in; wcen_ff <= wcen_in;
      wsize_ff <= wsize_in; wcolor_ff <= wcolor_in;
      for (int i = 0; i < 3; i++) ang_ff[i] <= ang_in[i];
      trig_acc_ff <= trig_acc_in; ang_sel_ff <= ang_sel_in;
      ent_ff <= ent_in; lim_ff <= lim_in; ph_ff <= ph_in;
      px_ff <= px_in; py_ff <= py_in; pz_ff <= pz_in; t_ff <= t_in;
      acc_ff <= acc_in; d_ff <= d_in; a_ff <= a_in; b_ff <= b_in; sph_ff <= sph_in;
      rh_ff <= rh_in; rc_ff <= rc_in;
      if (reset) begin
         state_ff <= vsmr_pkg::ST_IDLE;
         rv_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         if (csr_write) count_ff <= csr_data;
      end
   end

   assign rsp_valid   = rv_ff;
   assign rsp_hit     = rh_ff;
   assign rsp_color_r = rc_ff[23:16];
   assign rsp_color_g = rc_ff[15:8];
   assign rsp_color_b = rc_ff[7:0];

endmodule
`default_nettype wire
